// ----- design/stq_pkg.sv -----
// Shared constants and types for the sorted timer queue.
package stq_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int TIME_WIDTH_DEF = 32;
    localparam int ID_WIDTH_DEF   = 8;

    localparam int ACTION_W    = 2;
    localparam int ID_PORT_W   = 8;
    localparam int TIME_PORT_W = 32;
    localparam int STATUS_W    = 3;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_ADD    = 2'd0;
    localparam action_t ACT_ADJUST = 2'd1;
    localparam action_t ACT_DELETE = 2'd2;
    localparam action_t ACT_TICK   = 2'd3;

    localparam status_t ST_DONE     = 3'd0;
    localparam status_t ST_EXPIRED  = 3'd1;
    localparam status_t ST_NONE     = 3'd2;
    localparam status_t ST_FULL     = 3'd3;
    localparam status_t ST_NOTFOUND = 3'd4;
    localparam status_t ST_DUP      = 3'd5;

endpackage

// ----- design/stq_store.sv -----
// Timer store memory: one write port and one registered read port.
module stq_store #(
    parameter int DEPTH      = stq_pkg::DEPTH_DEF,
    parameter int TIME_WIDTH = stq_pkg::TIME_WIDTH_DEF,
    parameter int ID_WIDTH   = stq_pkg::ID_WIDTH_DEF,
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                  clk,
    input  logic                  we,
    input  logic [IDX_W-1:0]      waddr,
    input  logic [TIME_WIDTH-1:0] wexp,
    input  logic [ID_WIDTH-1:0]   wid,
    input  logic [IDX_W-1:0]      raddr,
    output logic [TIME_WIDTH-1:0] rexp,
    output logic [ID_WIDTH-1:0]   rid
);

    logic [TIME_WIDTH-1:0] exp_mem [DEPTH];
    logic [ID_WIDTH-1:0]   id_mem  [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            exp_mem[waddr] <= wexp;
            id_mem[waddr]  <= wid;
        end
    end

    always_ff @(posedge clk)
    begin
        rexp <= exp_mem[raddr];
        rid  <= id_mem[raddr];
    end

endmodule

// ----- design/sorted_timer_queue_unit.sv -----
// Top level of the sorted timer queue: request sequencer, shared comparator and store.
//
// A transaction is taken at a rising edge where start is high and busy is low; the
// fields action, timer_id, new_expire and current_time are sampled there. busy stays
// high until the request is finished. Results appear on result_id, status and last for
// exactly one cycle, marked by result_valid; the receiver cannot stall them.
// Add, adjust and delete give one result; tick gives one result per expired timer,
// with last set on the final one, or a single none-expired result.
// All work goes through the store's single registered read port under a small
// sequencer. The id search reads and compares each entry up to and including the
// match; removal moves every entry behind the removed one up by one place, and
// insertion moves every entry with a later expiry back by one place. A tick removes
// expired timers from the head one at a time, then checks the new head, if any,
// before its final result; every result passes through the result register.
// Reset clears the occupancy, the sequencer and the result valid flag only; the store
// needs no clearing pass, since only entries below the occupancy are ever used. The next
// transaction may be started in the cycle in which the final result is shown.
module sorted_timer_queue_unit #(
    parameter int DEPTH      = stq_pkg::DEPTH_DEF,
    parameter int TIME_WIDTH = stq_pkg::TIME_WIDTH_DEF,
    parameter int ID_WIDTH   = stq_pkg::ID_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [stq_pkg::ACTION_W-1:0]     action,
    input  logic [stq_pkg::ID_PORT_W-1:0]    timer_id,
    input  logic [stq_pkg::TIME_PORT_W-1:0]  new_expire,
    input  logic [stq_pkg::TIME_PORT_W-1:0]  current_time,
    output logic                             busy,
    output logic                             result_valid,
    output logic [stq_pkg::ID_PORT_W-1:0]    result_id,
    output logic [stq_pkg::STATUS_W-1:0]     status,
    output logic                             last
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_FIND_RD  = 3'd1;
    localparam logic [2:0] S_FIND_CMP = 3'd2;
    localparam logic [2:0] S_REM_RD   = 3'd3;
    localparam logic [2:0] S_REM_WR   = 3'd4;
    localparam logic [2:0] S_INS_RD   = 3'd5;
    localparam logic [2:0] S_INS_CMP  = 3'd6;
    localparam logic [2:0] S_TICK_RD  = 3'd7;

    logic [2:0]            state_reg, state_next;
    logic [CNT_W-1:0]      occ_reg, occ_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    stq_pkg::action_t      act_reg, act_next;
    logic [ID_WIDTH-1:0]   id_reg, id_next;
    logic [TIME_WIDTH-1:0] key_reg, key_next;
    logic [ID_WIDTH-1:0]   pend_id_reg, pend_id_next;
    logic                  pend_vld_reg, pend_vld_next;
    logic                  tick_cmp_reg, tick_cmp_next;

    logic                  out_vld_reg, out_vld_next;
    logic [ID_WIDTH-1:0]   out_id_reg, out_id_next;
    stq_pkg::status_t      out_st_reg, out_st_next;
    logic                  out_last_reg, out_last_next;

    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [TIME_WIDTH-1:0] wexp;
    logic [ID_WIDTH-1:0]   wid;
    logic [IDX_W-1:0]      raddr;
    logic [TIME_WIDTH-1:0] rd_exp;
    logic [ID_WIDTH-1:0]   rd_id;

    logic                  exp_le;
    logic [CNT_W-1:0]      idx_inc;
    logic [CNT_W-1:0]      idx_dec;

    stq_store #(
        .DEPTH      (DEPTH),
        .TIME_WIDTH (TIME_WIDTH),
        .ID_WIDTH   (ID_WIDTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wexp  (wexp),
        .wid   (wid),
        .raddr (raddr),
        .rexp  (rd_exp),
        .rid   (rd_id)
    );

    assign exp_le  = (rd_exp <= key_reg);
    assign idx_inc = idx_reg + CNT_W'(1);
    assign idx_dec = idx_reg - CNT_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        idx_next      = idx_reg;
        act_next      = act_reg;
        id_next       = id_reg;
        key_next      = key_reg;
        pend_id_next  = pend_id_reg;
        pend_vld_next = pend_vld_reg;
        tick_cmp_next = 1'b0;
        out_vld_next  = 1'b0;
        out_id_next   = out_id_reg;
        out_st_next   = out_st_reg;
        out_last_next = out_last_reg;
        we            = 1'b0;
        waddr         = idx_reg[IDX_W-1:0];
        wexp          = rd_exp;
        wid           = rd_id;
        raddr         = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    act_next      = action;
                    id_next       = ID_WIDTH'(timer_id);
                    idx_next      = '0;
                    pend_vld_next = 1'b0;
                    if (action == stq_pkg::ACT_TICK)
                    begin
                        key_next   = TIME_WIDTH'(current_time);
                        state_next = S_TICK_RD;
                    end
                    else
                    begin
                        key_next   = TIME_WIDTH'(new_expire);
                        state_next = S_FIND_RD;
                    end
                end
            end

            S_FIND_RD:
            begin
                if (idx_reg == occ_reg)
                begin
                    if (act_reg != stq_pkg::ACT_ADD)
                    begin
                        out_vld_next  = 1'b1;
                        out_id_next   = id_reg;
                        out_st_next   = stq_pkg::ST_NOTFOUND;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else if (occ_reg == CNT_W'(DEPTH))
                    begin
                        out_vld_next  = 1'b1;
                        out_id_next   = id_reg;
                        out_st_next   = stq_pkg::ST_FULL;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = occ_reg;
                        state_next = S_INS_RD;
                    end
                end
                else
                begin
                    state_next = S_FIND_CMP;
                end
            end

            S_FIND_CMP:
            begin
                if (rd_id == id_reg)
                begin
                    if (act_reg == stq_pkg::ACT_ADD)
                    begin
                        out_vld_next  = 1'b1;
                        out_id_next   = id_reg;
                        out_st_next   = stq_pkg::ST_DUP;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_REM_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_FIND_RD;
                end
            end

            S_REM_RD:
            begin
                raddr = idx_inc[IDX_W-1:0];
                if (idx_inc >= occ_reg)
                begin
                    occ_next = occ_reg - CNT_W'(1);
                    priority if (act_reg == stq_pkg::ACT_ADJUST)
                    begin
                        idx_next   = occ_reg - CNT_W'(1);
                        state_next = S_INS_RD;
                    end
                    else if (act_reg == stq_pkg::ACT_TICK)
                    begin
                        state_next = S_TICK_RD;
                    end
                    else
                    begin
                        out_vld_next  = 1'b1;
                        out_id_next   = id_reg;
                        out_st_next   = stq_pkg::ST_DONE;
                        out_last_next = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_REM_WR;
                end
            end

            S_REM_WR:
            begin
                we         = 1'b1;
                idx_next   = idx_inc;
                state_next = S_REM_RD;
            end

            S_INS_RD:
            begin
                raddr = idx_dec[IDX_W-1:0];
                if (idx_reg == '0)
                begin
                    we            = 1'b1;
                    wexp          = key_reg;
                    wid           = id_reg;
                    occ_next      = occ_reg + CNT_W'(1);
                    out_vld_next  = 1'b1;
                    out_id_next   = id_reg;
                    out_st_next   = stq_pkg::ST_DONE;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                end
                else
                begin
                    state_next = S_INS_CMP;
                end
            end

            S_INS_CMP:
            begin
                we = 1'b1;
                if (!exp_le)
                begin
                    idx_next   = idx_dec;
                    state_next = S_INS_RD;
                end
                else
                begin
                    wexp          = key_reg;
                    wid           = id_reg;
                    occ_next      = occ_reg + CNT_W'(1);
                    out_vld_next  = 1'b1;
                    out_id_next   = id_reg;
                    out_st_next   = stq_pkg::ST_DONE;
                    out_last_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end

            S_TICK_RD:
            begin
                raddr = '0;
                if (tick_cmp_reg && exp_le)
                begin
                    if (pend_vld_reg)
                    begin
                        out_vld_next  = 1'b1;
                        out_id_next   = pend_id_reg;
                        out_st_next   = stq_pkg::ST_EXPIRED;
                        out_last_next = 1'b0;
                    end
                    pend_id_next  = rd_id;
                    pend_vld_next = 1'b1;
                    idx_next      = '0;
                    state_next    = S_REM_RD;
                end
                else if (tick_cmp_reg || occ_reg == '0)
                begin
                    out_vld_next  = 1'b1;
                    out_last_next = 1'b1;
                    if (pend_vld_reg)
                    begin
                        out_id_next = pend_id_reg;
                        out_st_next = stq_pkg::ST_EXPIRED;
                    end
                    else
                    begin
                        out_id_next = id_reg;
                        out_st_next = stq_pkg::ST_NONE;
                    end
                    state_next = S_IDLE;
                end
                else
                begin
                    tick_cmp_next = 1'b1;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            occ_reg      <= '0;
            pend_vld_reg <= 1'b0;
            tick_cmp_reg <= 1'b0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            pend_vld_reg <= pend_vld_next;
            tick_cmp_reg <= tick_cmp_next;
            out_vld_reg  <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        act_reg      <= act_next;
        id_reg       <= id_next;
        key_reg      <= key_next;
        pend_id_reg  <= pend_id_next;
        out_id_reg   <= out_id_next;
        out_st_reg   <= out_st_next;
        out_last_reg <= out_last_next;
    end

    assign busy         = (state_reg != S_IDLE);
    assign result_valid = out_vld_reg;
    assign result_id    = stq_pkg::ID_PORT_W'(out_id_reg);
    assign status       = out_st_reg;
    assign last         = out_last_reg;

endmodule
